// ===== hw/rtl/clas_pkg.sv =====
package clas_pkg;

    // Bounds of the splitter
    localparam int MAX_BACKSLASH_RUN = 32;
    localparam int MAX_ARGUMENTS     = 64;

    // Widths
    localparam int PEND_W  = $clog2(MAX_BACKSLASH_RUN + 1);
    localparam int ARG_W   = 7;
    localparam int ARGX_W  = ARG_W + 1;
    localparam int CHAR_W  = 8;
    localparam int KIND_W  = 2;
    localparam int TAIL_W  = 2;
    localparam int TOTAL_W = PEND_W + 1;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Result kinds
    localparam logic [KIND_W-1:0] OK_CHAR     = 2'd0;
    localparam logic [KIND_W-1:0] OK_END_ARG  = 2'd1;
    localparam logic [KIND_W-1:0] OK_END_LINE = 2'd2;
    localparam logic [KIND_W-1:0] OK_EMPTY    = 2'd3;

    // Input kinds
    localparam logic IK_CHAR = 1'b0;
    localparam logic IK_EOL  = 1'b1;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;

    // One decoded transaction: a burst of held backslashes, then up to two
    // single results (the second is always an end of line)
    typedef struct packed {
        logic [PEND_W-1:0] bs_cnt;
        logic [TAIL_W-1:0] t_cnt;
        logic [KIND_W-1:0] t0_kind;
        logic [CHAR_W-1:0] t0_char;
        logic [ARG_W-1:0]  t0_idx;
        logic [ARG_W-1:0]  t1_idx;
        logic              ovf;
    } t_cmd;

endpackage

// ===== hw/rtl/clas_front.sv =====
module clas_front
    import clas_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_kind,
    input  logic [CHAR_W-1:0] i_char_code,
    output logic              o_stall,
    input  logic              i_q_full,
    output logic              o_push,
    output t_cmd              o_cmd
);

    localparam logic [2:0] PH_START        = 3'd0;
    localparam logic [2:0] PH_FIRST_PLAIN  = 3'd1;
    localparam logic [2:0] PH_FIRST_QUOTED = 3'd2;
    localparam logic [2:0] PH_GAP          = 3'd3;
    localparam logic [2:0] PH_ARG          = 3'd4;

    logic [2:0]        r_phase, n_phase;
    logic [PEND_W-1:0] r_pend, n_pend;
    logic [1:0]        r_qcnt, n_qcnt;
    logic              r_qrun, n_qrun;
    logic [ARG_W-1:0]  r_argn, n_argn;
    logic              r_sat, n_sat;

    logic  eol, is_quote, is_blank, is_bslash;
    logic  later, clear, accept;
    t_cmd  cmd;

    assign eol       = (i_kind == IK_EOL);
    assign is_quote  = (i_char_code == CH_QUOTE);
    assign is_blank  = (i_char_code == CH_SPACE) || (i_char_code == CH_TAB);
    assign is_bslash = (i_char_code == CH_BSLASH);

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;

    // Classify one byte: next state and the results it releases
    always_comb begin
        n_phase = r_phase;
        n_pend  = r_pend;
        n_qcnt  = r_qcnt;
        n_qrun  = r_qrun;
        n_argn  = r_argn;
        n_sat   = r_sat;
        later   = 1'b0;
        clear   = 1'b0;
        cmd     = '0;

        // A quote run ends on anything but another quote of a later argument
        if (r_qrun && (eol || !is_quote || r_phase != PH_ARG)) begin
            if (n_qcnt == 2'd2) begin
                n_qcnt = 2'd0;
            end
            n_qrun = 1'b0;
        end

        unique case (r_phase) inside
            PH_START: begin
                if (eol) begin
                    cmd.t_cnt   = 2'd1;
                    cmd.t0_kind = OK_EMPTY;
                    clear       = 1'b1;
                end else if (is_quote) begin
                    n_phase = PH_FIRST_QUOTED;
                end else if (is_blank) begin
                    cmd.t_cnt   = 2'd1;
                    cmd.t0_kind = OK_END_ARG;
                    n_phase     = PH_GAP;
                end else begin
                    cmd.t_cnt   = 2'd1;
                    cmd.t0_kind = OK_CHAR;
                    cmd.t0_char = i_char_code;
                    n_phase     = PH_FIRST_PLAIN;
                end
            end
            PH_FIRST_PLAIN, PH_FIRST_QUOTED: begin
                if (eol) begin
                    cmd.t_cnt   = 2'd2;
                    cmd.t0_kind = OK_END_ARG;
                    cmd.t1_idx  = ARG_W'(1);
                    clear       = 1'b1;
                end else if ((r_phase == PH_FIRST_PLAIN) ? is_blank : is_quote) begin
                    cmd.t_cnt   = 2'd1;
                    cmd.t0_kind = OK_END_ARG;
                    n_phase     = PH_GAP;
                end else begin
                    cmd.t_cnt   = 2'd1;
                    cmd.t0_kind = OK_CHAR;
                    cmd.t0_char = i_char_code;
                end
            end
            PH_GAP: begin
                if (eol) begin
                    cmd.t_cnt   = 2'd1;
                    cmd.t0_kind = OK_END_LINE;
                    cmd.t0_idx  = r_argn + ARG_W'(1);
                    clear       = 1'b1;
                end else if (!is_blank) begin
                    // New argument; index sticks at the last slot
                    if ((ARGX_W'(r_argn) + ARGX_W'(1)) >= ARGX_W'(MAX_ARGUMENTS)) begin
                        n_sat = 1'b1;
                    end else begin
                        n_argn = r_argn + ARG_W'(1);
                    end
                    n_pend  = '0;
                    n_qcnt  = 2'd0;
                    n_qrun  = 1'b0;
                    n_phase = PH_ARG;
                    later   = 1'b1;
                end
            end
            default: begin
                if (eol) begin
                    cmd.bs_cnt  = r_pend;
                    cmd.t_cnt   = 2'd2;
                    cmd.t0_kind = OK_END_ARG;
                    cmd.t0_idx  = r_argn;
                    cmd.t1_idx  = r_argn + ARG_W'(1);
                    clear       = 1'b1;
                end else begin
                    later = 1'b1;
                end
            end
        endcase

        // Backslash and quote rules of later arguments
        if (later) begin
            cmd.t0_idx = n_argn;
            if (is_quote) begin
                if (n_qrun) begin
                    n_qcnt = n_qcnt + 2'd1;
                    if (n_qcnt == 2'd3) begin
                        cmd.t_cnt   = 2'd1;
                        cmd.t0_kind = OK_CHAR;
                        cmd.t0_char = CH_QUOTE;
                        n_qcnt      = 2'd0;
                    end
                end else begin
                    cmd.bs_cnt = n_pend >> 1;
                    if (n_pend[0]) begin
                        cmd.t_cnt   = 2'd1;
                        cmd.t0_kind = OK_CHAR;
                        cmd.t0_char = CH_QUOTE;
                    end else begin
                        n_qcnt = n_qcnt + 2'd1;
                    end
                    n_pend = '0;
                    n_qrun = 1'b1;
                end
            end else if (is_blank && n_qcnt == 2'd0) begin
                cmd.bs_cnt  = n_pend;
                cmd.t_cnt   = 2'd1;
                cmd.t0_kind = OK_END_ARG;
                n_pend      = '0;
                n_phase     = PH_GAP;
            end else if (is_bslash) begin
                if (n_pend >= PEND_W'(MAX_BACKSLASH_RUN)) begin
                    n_sat = 1'b1;
                end else begin
                    n_pend = n_pend + PEND_W'(1);
                end
            end else begin
                cmd.bs_cnt  = n_pend;
                cmd.t_cnt   = 2'd1;
                cmd.t0_kind = OK_CHAR;
                cmd.t0_char = i_char_code;
                n_pend      = '0;
            end
        end

        cmd.ovf = n_sat;

        // End of line returns everything to the start of line
        if (clear) begin
            n_phase = PH_START;
            n_pend  = '0;
            n_qcnt  = 2'd0;
            n_qrun  = 1'b0;
            n_argn  = '0;
            n_sat   = 1'b0;
        end
    end

    assign o_cmd  = cmd;
    assign o_push = accept && (cmd.bs_cnt != '0 || cmd.t_cnt != '0);

    // Line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_pend  <= '0;
            r_qcnt  <= 2'd0;
            r_qrun  <= 1'b0;
            r_argn  <= '0;
            r_sat   <= 1'b0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_pend  <= n_pend;
            r_qcnt  <= n_qcnt;
            r_qrun  <= n_qrun;
            r_argn  <= n_argn;
            r_sat   <= n_sat;
        end
    end

endmodule

// ===== hw/rtl/clas_queue.sv =====
module clas_queue
    import clas_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            r_cnt <= r_cnt + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    // Checks
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("queue read while empty");

    a_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
            r_cnt == $past(r_cnt) + QCNT_W'($past(i_push)) - QCNT_W'($past(i_pop)))
        else $error("queue level out of step with push and pop");

endmodule

// ===== hw/rtl/clas_back.sv =====
module clas_back
    import clas_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  t_cmd              i_cmd,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [KIND_W-1:0] o_out_kind,
    output logic [CHAR_W-1:0] o_out_char,
    output logic [ARG_W-1:0]  o_arg_index,
    output logic              o_overflow,
    output logic              o_last
);

    logic [TOTAL_W-1:0] r_sub;
    logic               r_valid;
    logic [KIND_W-1:0]  r_kind;
    logic [CHAR_W-1:0]  r_char;
    logic [ARG_W-1:0]   r_idx;
    logic               r_ovf, r_last;

    logic [TOTAL_W-1:0] total;
    logic               in_bs, is_t0, is_last, load;
    logic [KIND_W-1:0]  sel_kind;
    logic [CHAR_W-1:0]  sel_char;
    logic [ARG_W-1:0]   sel_idx;

    assign total   = TOTAL_W'(i_cmd.bs_cnt) + TOTAL_W'(i_cmd.t_cnt);
    assign in_bs   = r_sub < TOTAL_W'(i_cmd.bs_cnt);
    assign is_t0   = r_sub == TOTAL_W'(i_cmd.bs_cnt);
    assign is_last = r_sub == (total - TOTAL_W'(1));
    assign load    = i_cmd_valid && (!r_valid || !i_stall);
    assign o_pop   = load && is_last;

    // Pick the result at the current position of the command
    always_comb begin
        if (in_bs) begin
            sel_kind = OK_CHAR;
            sel_char = CH_BSLASH;
            sel_idx  = i_cmd.t0_idx;
        end else if (is_t0) begin
            sel_kind = i_cmd.t0_kind;
            sel_char = i_cmd.t0_char;
            sel_idx  = i_cmd.t0_idx;
        end else begin
            sel_kind = OK_END_LINE;
            sel_char = '0;
            sel_idx  = i_cmd.t1_idx;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind <= sel_kind;
            r_char <= sel_char;
            r_idx  <= sel_idx;
            r_ovf  <= i_cmd.ovf;
            r_last <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_sub   <= is_last ? '0 : r_sub + TOTAL_W'(1);
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid     = r_valid;
    assign o_out_kind  = r_kind;
    assign o_out_char  = r_char;
    assign o_arg_index = r_idx;
    assign o_overflow  = r_ovf;
    assign o_last      = r_last;

    // Checks
    a_pos_in_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid |-> r_sub < total)
        else $error("result position beyond end of command");

endmodule

// ===== hw/rtl/command_line_argument_splitter.sv =====
// Splits a streamed command line into arguments under the usual Windows rules.
// The front stage takes one byte or end-of-line transaction per cycle and
// decides at once what it releases; results leave one per cycle, unless the
// output is stalled, through a registered output. A byte usually gives zero
// or one result, but the byte that ends a run of held backslashes releases
// up to the held count plus one result, and end of line up to the held count
// plus two; the output releases such a transaction one result at a time. A
// four-entry command queue between the stages absorbs these bursts, so input
// is only stalled when the queue is full, that is when bursts or output
// stalls back up faster than the output drains them.
module command_line_argument_splitter
    import clas_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_kind,
    input  logic [CHAR_W-1:0] i_char_code,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [KIND_W-1:0] o_out_kind,
    output logic [CHAR_W-1:0] o_out_char,
    output logic [ARG_W-1:0]  o_arg_index,
    output logic              o_overflow,
    output logic              o_last
);

    logic q_full, q_push, q_valid, q_pop;
    t_cmd push_cmd, head_cmd;

    clas_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_kind      (i_kind),
        .i_char_code (i_char_code),
        .o_stall     (o_stall),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_cmd       (push_cmd)
    );

    clas_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    clas_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (head_cmd),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_kind  (o_out_kind),
        .o_out_char  (o_out_char),
        .o_arg_index (o_arg_index),
        .o_overflow  (o_overflow),
        .o_last      (o_last)
    );

endmodule
